// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent assertions used by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define TMWF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tmwf assertion failed");

// Clocked assertion that also holds during reset.
`define TMWF_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("tmwf assertion failed");

`endif

// ===== sv/tmwf_pkg.sv =====
// ----------------------------------------------------------------------------
// Trimmed mean window filter package
// Shared widths, types and constants of the three-axis trimmed mean filter.
// ----------------------------------------------------------------------------
package tmwf_pkg;

   localparam int WINDOW     = 10;
   localparam int SMP_W      = 32;
   localparam int SUM_W      = SMP_W + $clog2(WINDOW);
   localparam int DIV        = WINDOW - 2;
   localparam int HALF       = DIV / 2;
   localparam int Q_W        = 32;
   localparam int CNT_W      = $clog2(WINDOW);

   typedef logic signed [SMP_W-1:0] smp_type;
   typedef logic signed [SUM_W-1:0] sum_type;

   typedef struct packed {
      smp_type x;
      smp_type y;
      smp_type z;
   } xyz_type;

   typedef struct packed {
      sum_type sum;
      smp_type min_v;
      smp_type max_v;
   } agg_type;

   typedef struct packed {
      agg_type x;
      agg_type y;
      agg_type z;
   } agg3_type;

   typedef struct packed {
      logic trim;
      logic norm;
   } div_ctrl_type;

   localparam agg_type AGG_INIT = '{
      sum:   '0,
      min_v: {1'b0, {(SMP_W-1){1'b1}}},
      max_v: {1'b1, {(SMP_W-1){1'b0}}}
   };

   localparam agg3_type AGG3_INIT = '{x: AGG_INIT, y: AGG_INIT, z: AGG_INIT};

endpackage

// ===== sv/tmwf_req_if.sv =====
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel carrying one x, y, z position sample per item.
// ----------------------------------------------------------------------------
interface tmwf_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;

   modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

// ===== sv/tmwf_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Filtered result channel
// Valid/ready channel carrying one filtered x, y, z position per item.
// ----------------------------------------------------------------------------
interface tmwf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] filt_x;
   logic signed [31:0] filt_y;
   logic signed [31:0] filt_z;

   modport source (output valid, output filt_x, output filt_y, output filt_z, input ready);
   modport sink   (input valid, input filt_x, input filt_y, input filt_z, output ready);
endinterface

// ===== sv/tmwf_cell.sv =====
// ----------------------------------------------------------------------------
// Window cell
// Holds one window entry per axis and folds it into the running sum, minimum
// and maximum passed along the chain.
// ----------------------------------------------------------------------------
module tmwf_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               shift_en,
   input  tmwf_pkg::xyz_type  sample_in,
   input  tmwf_pkg::agg3_type agg_in,
   output tmwf_pkg::xyz_type  hist_out,
   output tmwf_pkg::agg3_type agg_out
);
   import tmwf_pkg::*;

   xyz_type  hist_ff;
   xyz_type  hist_in;
   agg3_type agg_ff;
   agg3_type agg_in_nxt;

   function automatic agg_type fold(input agg_type a, input smp_type v);
      agg_type r;
      r.sum   = a.sum + SUM_W'(v);
      r.min_v = (v < a.min_v) ? v : a.min_v;
      r.max_v = (v > a.max_v) ? v : a.max_v;
      return r;
   endfunction

   always_comb begin
      hist_in      = shift_en ? sample_in : hist_ff;
      agg_in_nxt.x = fold(agg_in.x, hist_ff.x);
      agg_in_nxt.y = fold(agg_in.y, hist_ff.y);
      agg_in_nxt.z = fold(agg_in.z, hist_ff.z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
      end else begin
         hist_ff <= hist_in;
      end
   end

   // Partial results move one cell down the chain every cycle.
   always_ff @(posedge clock) begin
      agg_ff <= agg_in_nxt;
   end

   assign hist_out = hist_ff;
   assign agg_out  = agg_ff;

endmodule

// ===== sv/tmwf_div.sv =====
// ----------------------------------------------------------------------------
// Trimmed mean divider
// Removes the extremes from the window sum and divides by the trimmed count,
// rounding to nearest with ties away from zero.
// ----------------------------------------------------------------------------
module tmwf_div (
   input  logic                   clock,
   input  tmwf_pkg::div_ctrl_type ctrl,
   input  tmwf_pkg::agg_type      agg,
   output tmwf_pkg::smp_type      result
);
   import tmwf_pkg::*;

   sum_type          trim_ff;
   logic             neg_ff;
   logic [Q_W-1:0]   quo_ff;
   logic [SUM_W-1:0] num;

   // Magnitude plus half the divisor, formed with a single adder per sign.
   always_comb begin
      if (trim_ff < 0) begin
         num = SUM_W'(HALF) - trim_ff;
      end else begin
         num = trim_ff + SUM_W'(HALF);
      end
   end

   // The trimmed count is a constant power of two, so the divide below is a
   // plain right shift of the rounded magnitude.
   always_ff @(posedge clock) begin
      if (ctrl.trim) begin
         trim_ff <= agg.sum - SUM_W'(agg.min_v) - SUM_W'(agg.max_v);
      end
      if (ctrl.norm) begin
         neg_ff <= (trim_ff < 0);
         quo_ff <= Q_W'(num / SUM_W'(DIV));
      end
   end

   assign result = neg_ff ? $signed(SMP_W'(0 - quo_ff)) : $signed(quo_ff);

endmodule

// ===== sv/trimmed_mean_window_filter_3ch_top.sv =====
// ----------------------------------------------------------------------------
// Three-axis trimmed mean window filter
// Sliding window of the last WINDOW position samples per axis; the result is
// the window mean with one smallest and one largest sample removed.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake      Payload
//   req_ch    in         valid / ready  pos_x, pos_y, pos_z   (signed 32 bit)
//   rsp_ch    out        valid / ready  filt_x, filt_y, filt_z (signed 32 bit)
//
// An accepted item is processed in order: the partial sums ripple through the
// chain of WINDOW cells, the trim state removes the extremes, and the norm
// state rounds and divides; the result is then offered, and the next item can
// be accepted once the result has moved into the output register.
// The result sits in an output register, so a new item is accepted while it
// waits; a stalled result only holds back the following one when it is done.
// Reset clears the window to zeros and drops any pending result.
//
module trimmed_mean_window_filter_3ch_top (
   input logic        clock,
   input logic        reset,
   tmwf_req_if.sink   req_ch,
   tmwf_rsp_if.source rsp_ch
);
   import tmwf_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_TRIM   = 3'd2;
   localparam logic [2:0] ST_NORM   = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0]       state_ff;
   logic [2:0]       state_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   xyz_type          out_ff;
   xyz_type          out_in;
   logic             accept;
   logic             load_out;
   xyz_type          new_smp;
   div_ctrl_type     div_ctrl;
   xyz_type          div_res;

   xyz_type  hist_w [WINDOW];
   agg3_type agg_w  [WINDOW];

   assign accept   = req_ch.valid && req_ch.ready;
   assign new_smp  = {req_ch.pos_x, req_ch.pos_y, req_ch.pos_z};
   assign load_out = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ch.ready);

   // The window is a chain of cells: on an accepted item every cell takes
   // its neighbor's sample, and the newest sample enters the first cell.
   // The sum, minimum and maximum then travel one cell per cycle.
   for (genvar k = 0; k < WINDOW; k++) begin : g_cell
      if (k == 0) begin : g_head
         tmwf_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .shift_en  (accept),
            .sample_in (new_smp),
            .agg_in    (AGG3_INIT),
            .hist_out  (hist_w[k]),
            .agg_out   (agg_w[k])
         );
      end else begin : g_body
         tmwf_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .shift_en  (accept),
            .sample_in (hist_w[k-1]),
            .agg_in    (agg_w[k-1]),
            .hist_out  (hist_w[k]),
            .agg_out   (agg_w[k])
         );
      end
   end

   // One divider per axis, all driven by the same sequence.
   assign div_ctrl.trim = (state_ff == ST_TRIM);
   assign div_ctrl.norm = (state_ff == ST_NORM);

   tmwf_div u_div_x (
      .clock  (clock),
      .ctrl   (div_ctrl),
      .agg    (agg_w[WINDOW-1].x),
      .result (div_res.x)
   );

   tmwf_div u_div_y (
      .clock  (clock),
      .ctrl   (div_ctrl),
      .agg    (agg_w[WINDOW-1].y),
      .result (div_res.y)
   );

   tmwf_div u_div_z (
      .clock  (clock),
      .ctrl   (div_ctrl),
      .agg    (agg_w[WINDOW-1].z),
      .result (div_res.z)
   );

   // Sequencer: wait for the chain to settle, trim, round and divide, then
   // hand the result to the output register once it is free.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
               cnt_in   = '0;
            end
         end
         ST_SCAN: begin
            if (cnt_ff == CNT_W'(WINDOW - 1)) begin
               state_in = ST_TRIM;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_TRIM: begin
            state_in = ST_NORM;
         end
         ST_NORM: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_in       = load_out ? div_res : out_ff;
      rsp_valid_in = load_out || (rsp_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign req_ch.ready  = (state_ff == ST_IDLE);
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.filt_x = out_ff.x;
   assign rsp_ch.filt_y = out_ff.y;
   assign rsp_ch.filt_z = out_ff.z;

endmodule

// ===== sv/tmwf_checker.sv =====
// ----------------------------------------------------------------------------
// Trimmed mean filter checker
// Port-level checks of the filter's handshakes, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tmwf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] filt_x,
   input logic [31:0] filt_y,
   input logic [31:0] filt_z
);

   // Reset drops any pending result.
   `TMWF_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_valid)

   // One item at a time: the block is busy right after taking an item.
   `TMWF_ASSERT(a_busy_after_accept, clock, reset, (req_valid && req_ready) |=> !req_ready)

   // A stalled result stays put.
   `TMWF_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(filt_x) && $stable(filt_y) && $stable(filt_z)))

   // A result is withdrawn only after it was taken.
   `TMWF_ASSERT(a_rsp_taken, clock, reset, ($fell(rsp_valid) && !$past(reset)) |-> $past(rsp_ready))

endmodule

bind trimmed_mean_window_filter_3ch_top tmwf_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .filt_x    (rsp_ch.filt_x),
   .filt_y    (rsp_ch.filt_y),
   .filt_z    (rsp_ch.filt_z)
);
